FILE: src/cal_pkg.sv
// Shared types and codes for the compacting array list.
// No dependencies; imported by cal_cell, compacting_array_list_core and the testbench.
`default_nettype none

package cal_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int CAL_DEPTH      = 128;
    localparam int CAL_DATA_WIDTH = 32;

    // Index width that covers the largest supported depth and any position.
    localparam int CAL_IDX_W = 13;

    // Operation codes.
    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_RM_TAIL = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic                 wr_en;
        logic                 shift_en;
        logic                 rd_go;
        logic [CAL_IDX_W-1:0] sel;
    } t_cal_ctrl;

endpackage

`default_nettype wire

FILE: src/cal_cell.sv
// One storage cell of the list chain: holds one entry and one slot of the
// read return path. Depends on cal_pkg.
`default_nettype none

module cal_cell
    import cal_pkg::*;
#(
    parameter int DATA_WIDTH = CAL_DATA_WIDTH,
    parameter int CELL_IDX   = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cal_ctrl             i_ctrl,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic [DATA_WIDTH-1:0] i_next_word,
    input  wire logic                  i_next_rd_vld,
    input  wire logic [DATA_WIDTH-1:0] i_next_rd_word,
    output logic      [DATA_WIDTH-1:0] o_word,
    output logic                       o_rd_vld,
    output logic      [DATA_WIDTH-1:0] o_rd_word
);

    localparam logic [CAL_IDX_W-1:0] MY_IDX = CAL_IDX_W'(CELL_IDX);

    logic                  r_rd_vld;
    logic [DATA_WIDTH-1:0] r_rd_word;
    logic [DATA_WIDTH-1:0] r_word;
    logic                  w_hit;

    assign w_hit = (i_ctrl.sel == MY_IDX);

    // Entry storage: an append lands on the cell at the tail, a removal pulls
    // every entry at or above the removed position down by one.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && w_hit) begin
            r_word <= i_wdata;
        end else if (i_ctrl.shift_en && (MY_IDX >= i_ctrl.sel)) begin
            r_word <= i_next_word;
        end
    end

    // Read return path: the selected cell launches its word, which then moves
    // one cell toward the head each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_ctrl.rd_go && w_hit) begin
            r_rd_vld <= 1'b1;
        end else begin
            r_rd_vld <= i_next_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_go && w_hit) begin
            r_rd_word <= r_word;
        end else begin
            r_rd_word <= i_next_rd_word;
        end
    end

    assign o_word    = r_word;
    assign o_rd_vld  = r_rd_vld;
    assign o_rd_word = r_rd_word;

endmodule

`default_nettype wire

FILE: src/compacting_array_list_core.sv
// Append, remove, remove-tail, clear and unused codes show their result in the cycle after
// the transfer, and a new item may follow every cycle while o_in_stall is low. A read of
// entry k returns through the return path of the cell chain; no item is taken meanwhile.
// Reset (synchronous, active low) empties the list and drops pending results; entry contents
// are kept and are unreadable until written again.
// Top level: controller, output register and a chain of cal_cell; depends on cal_pkg.
`default_nettype none

module compacting_array_list_core
    import cal_pkg::*;
#(
    parameter int DEPTH      = CAL_DEPTH,
    parameter int DATA_WIDTH = CAL_DATA_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic [7:0]  i_position,
    input  wire logic [31:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_read_word,
    output logic      [1:0]  o_status,
    output logic      [7:0]  o_item_total
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_rd_busy;
    logic                  r_out_valid;
    logic [31:0]           r_read_word;
    logic [1:0]            r_status;
    logic [7:0]            r_item_total;

    logic                  w_in_fire;
    logic                  w_out_fire;
    t_cal_ctrl             w_cmd;
    t_cal_ctrl             w_ctrl;
    logic [1:0]            w_status;
    logic [CAL_IDX_W-1:0]  w_cnt_x;
    logic [CAL_IDX_W-1:0]  w_ncnt_x;
    logic [CAL_IDX_W-1:0]  w_pos_x;
    logic [CAL_IDX_W-1:0]  w_mag;
    logic [63:0]           w_val64;
    logic [63:0]           w_rd64;
    logic [DATA_WIDTH-1:0] w_wdata;

    logic [DATA_WIDTH-1:0] w_word    [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd_word [DEPTH+1];
    logic [DEPTH:0]        w_rd_vld;

    assign o_in_stall = r_rd_busy || (r_out_valid && i_out_stall);
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_out_fire = r_out_valid && !i_out_stall;

    assign w_cnt_x  = CAL_IDX_W'(r_count);
    assign w_ncnt_x = CAL_IDX_W'(n_count);
    assign w_pos_x  = {{(CAL_IDX_W-8){i_position[7]}}, i_position};
    assign w_mag    = i_position[7] ? (~w_pos_x + CAL_IDX_W'(1)) : w_pos_x;
    assign w_val64  = 64'(i_value);
    assign w_wdata  = w_val64[DATA_WIDTH-1:0];

    // Operation decode.
    always_comb begin
        w_cmd    = '0;
        w_status = ST_OK;
        n_count  = r_count;
        unique case (i_op)
            OP_APPEND: begin
                if (r_count == CW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.wr_en = 1'b1;
                    w_cmd.sel   = w_cnt_x;
                    n_count     = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (i_position[7] || (w_pos_x >= w_cnt_x)) begin
                    w_status = ST_RANGE;
                end else begin
                    w_cmd.shift_en = 1'b1;
                    w_cmd.sel      = w_pos_x;
                    n_count        = r_count - CW'(1);
                end
            end
            OP_READ: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_mag >= w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_cmd.rd_go = 1'b1;
                    w_cmd.sel   = i_position[7] ? (w_cnt_x - w_mag) : w_pos_x;
                end
            end
            OP_RM_TAIL: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_ctrl          = w_cmd;
        w_ctrl.wr_en    = w_cmd.wr_en && w_in_fire;
        w_ctrl.shift_en = w_cmd.shift_en && w_in_fire;
        w_ctrl.rd_go    = w_cmd.rd_go && w_in_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_busy <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_count <= n_count;
            end
            if (w_ctrl.rd_go) begin
                r_rd_busy <= 1'b1;
            end else if (w_rd_vld[0]) begin
                r_rd_busy <= 1'b0;
            end
        end
    end

    // Output register. A read leaves it empty until its word reaches the head
    // cell; every other operation fills it on the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_in_fire && !w_cmd.rd_go) || w_rd_vld[0]) begin
            r_out_valid <= 1'b1;
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign w_rd64 = 64'(w_rd_word[0]);

    always_ff @(posedge i_clk) begin
        if (w_rd_vld[0]) begin
            r_read_word  <= w_rd64[31:0];
            r_status     <= ST_OK;
            r_item_total <= w_cnt_x[7:0];
        end else if (w_in_fire && !w_cmd.rd_go) begin
            r_read_word  <= '0;
            r_status     <= w_status;
            r_item_total <= w_ncnt_x[7:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_word  = r_read_word;
    assign o_status     = r_status;
    assign o_item_total = r_item_total;

    // The end of the chain feeds an empty return slot.
    assign w_rd_vld[DEPTH]  = 1'b0;
    assign w_rd_word[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_next_word;

        if (g == DEPTH - 1) begin : g_last
            assign w_next_word = w_word[g];
        end else begin : g_mid
            assign w_next_word = w_word[g+1];
        end

        cal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (w_ctrl),
            .i_wdata        (w_wdata),
            .i_next_word    (w_next_word),
            .i_next_rd_vld  (w_rd_vld[g+1]),
            .i_next_rd_word (w_rd_word[g+1]),
            .o_word         (w_word[g]),
            .o_rd_vld       (w_rd_vld[g]),
            .o_rd_word      (w_rd_word[g])
        );
    end

`ifndef SYNTHESIS
    // At most one read word travels the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_rd_vld))
        else $error("more than one read word in flight");

    // A read word only arrives while a read is outstanding.
    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_vld[0] |-> r_rd_busy)
        else $error("read word arrived with no read pending");

    // A launched read holds off further transfers on the next cycle.
    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.rd_go |=> (r_rd_busy && o_in_stall))
        else $error("read launched without blocking input");

    // The fill count never passes the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_x <= CAL_IDX_W'(DEPTH))
        else $error("element count above depth");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for compacting_array_list_core: directed table, fill to capacity,
// then random operation mixes under varying idle and stall patterns on both channels.
// Depends on cal_pkg for operation and status codes.
`default_nettype none

module testbench;
    import cal_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int LIMIT_CYCLES = 600_000;
    localparam int DRAIN_LIMIT  = 5_000;
    localparam int TAIL_CYCLES  = CAL_DEPTH + 20;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  status;
        logic [7:0]  total;
    } t_list_result;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [7:0]  pos;
        logic [31:0]        val;
        bit                 typed;
        logic [31:0]        word;
        logic [1:0]         status;
        logic [7:0]         total;
    } t_step_row;

    // Rows with typed set carry a result that is obvious by inspection; the rest use the
    // predictor.
    localparam t_step_row DIRECTED_STEPS [23] = '{
        '{OP_READ,      0, 32'h0,         1, 32'h0,         ST_EMPTY, 8'd0},
        '{OP_REMOVE,    0, 32'h0,         1, 32'h0,         ST_EMPTY, 8'd0},
        '{OP_RM_TAIL,   0, 32'h0,         1, 32'h0,         ST_EMPTY, 8'd0},
        '{OP_CLEAR,     0, 32'h0,         1, 32'h0,         ST_OK,    8'd0},
        '{OP_APPEND,    0, 32'hFFFF_FFFF, 1, 32'h0,         ST_OK,    8'd1},
        '{OP_APPEND,  127, 32'h0,         1, 32'h0,         ST_OK,    8'd2},
        '{OP_APPEND, -127, 32'hA5A5_5A5A, 1, 32'h0,         ST_OK,    8'd3},
        '{OP_READ,      0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, ST_OK,    8'd3},
        '{OP_READ,     -1, 32'h0,         1, 32'hA5A5_5A5A, ST_OK,    8'd3},
        '{OP_READ,     -2, 32'h0,         1, 32'h0,         ST_OK,    8'd3},
        '{OP_READ,     -3, 32'h0,         1, 32'h0,         ST_RANGE, 8'd3},
        '{OP_READ,      3, 32'h0,         1, 32'h0,         ST_RANGE, 8'd3},
        '{OP_READ,    127, 32'h0,         1, 32'h0,         ST_RANGE, 8'd3},
        '{OP_READ,   -127, 32'h0,         1, 32'h0,         ST_RANGE, 8'd3},
        '{OP_REMOVE,   -1, 32'h0,         1, 32'h0,         ST_RANGE, 8'd3},
        '{OP_REMOVE,    3, 32'h0,         1, 32'h0,         ST_RANGE, 8'd3},
        '{OP_REMOVE,    1, 32'h0,         0, 32'h0,         ST_OK,    8'd0},
        '{OP_READ,      1, 32'h0,         0, 32'h0,         ST_OK,    8'd0},
        '{OP_UNUSED_LO, 0, 32'h1234_5678, 1, 32'h0,         ST_OK,    8'd2},
        '{OP_UNUSED_HI,-1, 32'h0,         1, 32'h0,         ST_OK,    8'd2},
        '{OP_RM_TAIL,   0, 32'h0,         0, 32'h0,         ST_OK,    8'd0},
        '{OP_APPEND,    0, 32'h8000_0001, 0, 32'h0,         ST_OK,    8'd0},
        '{OP_CLEAR,     5, 32'h0,         1, 32'h0,         ST_OK,    8'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_op;
    logic [7:0]  i_position;
    logic [31:0] i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_read_word;
    logic [1:0]  o_status;
    logic [7:0]  o_item_total;

    compacting_array_list_core #(
        .DEPTH      (CAL_DEPTH),
        .DATA_WIDTH (CAL_DATA_WIDTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_word  (o_read_word),
        .o_status     (o_status),
        .o_item_total (o_item_total)
    );

    // Shadow copy of the list.
    logic [31:0]  list_words [CAL_DEPTH];
    int           list_len = 0;
    int           peak_len = 0;

    t_list_result pending_results [$];
    bit           typed_pending = 1'b0;
    t_list_result typed_expect  = '0;

    int unsigned  send_idle_pct = 24;
    int unsigned  recv_idle_pct = 66;
    bit           hold_req      = 1'b0;
    int unsigned  hold_len      = 0;
    int unsigned  hold_count    = 0;

    bit           grow_mode  = 1'b1;
    int           len_target = CAL_DEPTH;

    int unsigned  error_count   = 0;
    int unsigned  items_taken   = 0;
    int unsigned  results_seen  = 0;
    int unsigned  full_flags    = 0;
    int unsigned  range_flags   = 0;
    int unsigned  cycle_count   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
        error_count++;
    endtask

    // Applies one operation to the shadow list and returns the result it must produce.
    function automatic t_list_result list_model_apply(input logic [2:0] op,
                                                      input logic [7:0] pos,
                                                      input logic [31:0] val);
        t_list_result r;
        int           p;
        int           mag;
        int           k;
        r = '0;
        p = int'($signed(pos));
        case (op)
            OP_APPEND: begin
                if (list_len >= CAL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 0 || p >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = p; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
                    list_len--;
                end
            end
            OP_READ: begin
                mag = (p < 0) ? -p : p;
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (mag > list_len - 1) begin
                    r.status = ST_RANGE;
                end else begin
                    r.word = list_words[(p >= 0) ? p : list_len + p];
                end
            end
            OP_RM_TAIL: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        if (list_len > peak_len) peak_len = list_len;
        r.total = 8'(list_len);
        return r;
    endfunction

    // Input and output transfers, both taken at the rising edge. The output side is checked
    // first so that a transfer in the same edge cannot be matched against its own input.
    always @(posedge i_clk) begin : transfer_monitor
        t_list_result want;
        t_list_result predicted;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result status", 32'(o_status), 32'h0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_read_word !== want.word)
                        report_mismatch("read_word", o_read_word, want.word);
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_item_total !== want.total)
                        report_mismatch("item_total", 32'(o_item_total), 32'(want.total));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predicted = list_model_apply(i_op, i_position, i_value);
                if (predicted.status == ST_FULL) full_flags++;
                if (predicted.status == ST_RANGE) range_flags++;
                pending_results.push_back(typed_pending ? typed_expect : predicted);
                items_taken++;
            end
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(negedge i_clk);
                hold_count++;
                hold_req = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [2:0] op, input logic [7:0] pos, input logic [31:0] val,
                             input bit typed, input t_list_result typed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_position    <= pos;
        i_value       <= val;
        typed_pending = typed;
        typed_expect  = typed_res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random operations that alternately grow the list toward a target and shrink it again,
    // so that full, nearly empty and every occupancy in between are visited.
    task automatic send_random_items(input int unsigned n);
        int unsigned pick;
        int          p;
        logic [2:0]  op;
        repeat (n) begin
            if (grow_mode && list_len >= len_target && $urandom_range(3) == 0) begin
                grow_mode  = 1'b0;
                len_target = $urandom_range(0, list_len / 2);
            end else if (!grow_mode && list_len <= len_target) begin
                grow_mode  = 1'b1;
                len_target = ($urandom_range(3) == 0) ? CAL_DEPTH
                                                      : $urandom_range(list_len + 1, CAL_DEPTH);
            end
            pick = $urandom_range(99);
            if (grow_mode)
                op = (pick < 55) ? OP_APPEND : (pick < 65) ? OP_REMOVE :
                     (pick < 88) ? OP_READ : (pick < 94) ? OP_RM_TAIL :
                     (pick < 95) ? OP_CLEAR : 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
                op = (pick < 15) ? OP_APPEND : (pick < 45) ? OP_REMOVE :
                     (pick < 72) ? OP_READ : (pick < 94) ? OP_RM_TAIL :
                     (pick < 96) ? OP_CLEAR : 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            pick = $urandom_range(99);
            if (list_len == 0 || pick < 20)
                p = int'($urandom_range(0, 254)) - 127;
            else if (pick < 28)
                p = (list_len > 127) ? 127 : (($urandom_range(1) != 0) ? list_len : -list_len);
            else if (op == OP_READ && list_len > 1 && $urandom_range(1) != 0)
                p = -int'($urandom_range(1, list_len - 1));
            else
                p = int'($urandom_range(0, list_len - 1));
            send_item(op, 8'(p), $urandom, 1'b0, '0);
        end
    endtask

    // Stops offering items and waits until every expected result has arrived or DRAIN_LIMIT runs out.
    task automatic wait_results_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        @(negedge i_clk);
    endtask

    initial begin
        t_list_result typed_res;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_op       = OP_APPEND;
        i_position = 8'h00;
        i_value    = 32'h0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < $size(DIRECTED_STEPS); i++) begin
            typed_res.word   = DIRECTED_STEPS[i].word;
            typed_res.status = DIRECTED_STEPS[i].status;
            typed_res.total  = DIRECTED_STEPS[i].total;
            send_item(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].pos, DIRECTED_STEPS[i].val,
                      DIRECTED_STEPS[i].typed, typed_res);
        end

        // Fill to capacity, then probe the full flag and the far ends of the index range.
        while (list_len < CAL_DEPTH)
            send_item(OP_APPEND, 8'($urandom), $urandom, 1'b0, '0);
        send_item(OP_APPEND, 8'd0, $urandom, 1'b0, '0);
        send_item(OP_READ, 8'd127, 32'h0, 1'b0, '0);
        send_item(OP_READ, 8'(-127), 32'h0, 1'b0, '0);
        send_item(OP_REMOVE, 8'd127, 32'h0, 1'b0, '0);
        send_item(OP_REMOVE, 8'd0, 32'h0, 1'b0, '0);
        send_item(OP_APPEND, 8'd0, $urandom, 1'b0, '0);
        send_item(OP_READ, 8'd126, 32'h0, 1'b0, '0);

        send_random_items(40);
        // Long receiver hold-off while items keep coming, so the block backs up.
        hold_len = 80;
        hold_req = 1'b1;
        send_random_items(190);

        send_idle_pct = 66;
        recv_idle_pct = 24;
        send_random_items(110);
        wait_results_drained();
        send_random_items(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_items(230);

        wait_results_drained();
        if (pending_results.size() != 0)
            report_mismatch("missing results", 32'(pending_results.size()), 32'h0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d operations and %0d results; %0d full flags, %0d range errors,",
                 items_taken, results_seen, full_flags, range_flags);
        $display("peak occupancy %0d of %0d, %0d receiver hold-offs.",
                 peak_len, CAL_DEPTH, hold_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
